### rtl/png_stored_deflate_encoder_assert.svh
// Assertion macros for the PNG stored-deflate encoder.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef PNG_STORED_DEFLATE_ENCODER_ASSERT_SVH
`define PNG_STORED_DEFLATE_ENCODER_ASSERT_SVH
`ifndef SYNTH
`define PSDE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");
`define PSDE_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define PSDE_ASSERT(label, prop)
`define PSDE_ASSERT_RST(label, prop)
`endif
`endif

### rtl/psde_pkg.sv
// Shared types, constants and functions of the PNG stored-deflate encoder.
// No dependencies.
`timescale 1ns / 1ps
package psde_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_W      = 13;
  localparam int ROWB_W     = 15;
  localparam int ROW_W      = 13;
  localparam int TOTAL_W    = 27;
  localparam int BLK_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = 1;
  localparam int Q_CNT_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [15:0] ADLER_MOD = 16'd65521;
  localparam logic [15:0] BLOCK_MAX = 16'd65535;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       row_start;
    logic       finish;
  } psde_cmd_t;

  function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_WIDTH)) r = DIM_W'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_HEIGHT)) r = DIM_W'(MAX_HEIGHT);
    return r;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] signature(input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0:    r = 8'd137;
      3'd1:    r = 8'd80;
      3'd2:    r = 8'd78;
      3'd3:    r = 8'd71;
      3'd4:    r = 8'd13;
      3'd5:    r = 8'd10;
      3'd6:    r = 8'd26;
      default: r = 8'd10;
    endcase
    return r;
  endfunction

endpackage

### rtl/psde_front.sv
// Front end: accepts frame bytes and tags each with file, row and end flags.
// Depends on psde_pkg.
`timescale 1ns / 1ps
module psde_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      cfg_we,
  input  logic [psde_pkg::DIM_W-1:0] eff_w,
  input  logic [psde_pkg::DIM_W-1:0] eff_h,
  input  logic                      q_ready,
  output logic                      q_valid,
  output psde_pkg::psde_cmd_t       q_cmd
);

  logic                          in_file_r, in_file_nxt;
  logic [psde_pkg::ROWB_W-1:0]   rbc_r, rbc_nxt, rbc_cur, row_len;
  logic [psde_pkg::ROW_W-1:0]    row_r, row_nxt, row_cur;
  logic                          row_end, last_row, accept;

  assign in_ready  = q_ready;
  assign q_valid   = in_valid;
  assign accept    = in_valid && q_ready;
  assign row_len   = {eff_w, 2'b00};
  assign rbc_cur   = in_file_r ? rbc_r : '0;
  assign row_cur   = in_file_r ? row_r : '0;
  assign row_end   = (rbc_cur + 1'b1) == row_len;
  assign last_row  = (row_cur + 1'b1) == eff_h;

  assign q_cmd.data      = in_data_byte;
  assign q_cmd.start     = !in_file_r;
  assign q_cmd.row_start = (rbc_cur == '0);
  assign q_cmd.finish    = row_end && last_row;

  always_comb begin
    in_file_nxt = in_file_r;
    rbc_nxt     = rbc_r;
    row_nxt     = row_r;
    if (accept) begin
      in_file_nxt = !(row_end && last_row);
      if (row_end) begin
        rbc_nxt = '0;
        row_nxt = row_cur + 1'b1;
      end else begin
        rbc_nxt = rbc_cur + 1'b1;
        row_nxt = row_cur;
      end
    end
    if (cfg_we) in_file_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_file_r <= 1'b0;
      rbc_r     <= '0;
      row_r     <= '0;
    end else begin
      in_file_r <= in_file_nxt;
      rbc_r     <= rbc_nxt;
      row_r     <= row_nxt;
    end
  end

endmodule

### rtl/psde_fifo.sv
// Short command queue between front and back end.
// Depends on psde_pkg.
`timescale 1ns / 1ps
module psde_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_valid,
  output logic                        wr_ready,
  input  psde_pkg::psde_cmd_t         wr_cmd,
  output logic                        rd_valid,
  input  logic                        rd_pop,
  output psde_pkg::psde_cmd_t         rd_cmd,
  output logic [psde_pkg::Q_CNT_W-1:0] count
);

  psde_pkg::psde_cmd_t                mem_r [psde_pkg::Q_DEPTH];
  logic [psde_pkg::Q_PTR_W-1:0]       wp_r, rp_r;
  logic [psde_pkg::Q_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                               push, pop;

  assign wr_ready = cnt_r != psde_pkg::Q_CNT_W'(psde_pkg::Q_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_cmd   = mem_r[rp_r];
  assign count    = cnt_r;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/psde_back.sv
// Back end: byte sequencer that writes headers, stored blocks and trailers,
// with running CRC-32 and Adler-32. Depends on psde_pkg.
`timescale 1ns / 1ps
module psde_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [psde_pkg::DIM_W-1:0] eff_w,
  input  logic [psde_pkg::DIM_W-1:0] eff_h,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  psde_pkg::psde_cmd_t        q_cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_last_of_run,
  output logic                       out_file_end
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_BHDR = 3'd2;
  localparam logic [2:0] ST_PAY  = 3'd3;
  localparam logic [2:0] ST_TAIL = 3'd4;

  localparam logic [5:0] HDR_LAST  = 6'd42;
  localparam logic [5:0] TAIL_LAST = 6'd19;
  localparam logic [5:0] BHDR_LAST = 6'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [5:0]                    idx_r, idx_nxt;
  psde_pkg::psde_cmd_t           cmd_r;
  logic                          filt_r, filt_nxt;
  logic [31:0]                   crc_r, crc_nxt;
  logic [15:0]                   alo_r, alo_nxt, ahi_r, ahi_nxt;
  logic [psde_pkg::BLK_W-1:0]    brem_r, brem_nxt;
  logic [psde_pkg::TOTAL_W-1:0]  fleft_r, fleft_nxt;
  logic [psde_pkg::TOTAL_W-1:0]  total_r;
  logic [12:0]                   nb_r;
  logic [31:0]                   idat_len_r;
  logic                          ov_r;
  logic [7:0]                    ob_r;
  logic                          ol_r, oe_r;

  logic                          adv, emit, crc_en, crc_rst, last, fend;
  logic [7:0]                    byte_v;
  logic [15:0]                   blk_n;
  logic [16:0]                   lo_s, hi_s;
  logic [15:0]                   lo_n, hi_n;
  logic [27:0]                   nb_x;
  logic [16:0]                   nb_r17;
  logic [28:0]                   prod;

  assign adv = !ov_r || out_ready;
  assign q_pop = (state_r == ST_IDLE);

  // size of the next stored block
  assign blk_n = (fleft_r < psde_pkg::TOTAL_W'(psde_pkg::BLOCK_MAX)) ?
                 fleft_r[15:0] : psde_pkg::BLOCK_MAX;

  // frame size terms, refreshed every cycle from the dimensions
  assign prod   = 29'({{eff_w, 2'b00} + 15'd1} * {2'b00, eff_h});
  assign nb_x   = 28'(total_r) + 28'(psde_pkg::BLOCK_MAX - 16'd1);
  assign nb_r17 = 17'(nb_x[15:0]) + 17'(nb_x[27:16]);

  always_ff @(posedge clk) begin
    total_r    <= prod[psde_pkg::TOTAL_W-1:0];
    nb_r       <= 13'(nb_x[27:16]) + 13'(nb_r17 >= 17'(psde_pkg::BLOCK_MAX));
    idat_len_r <= 32'd6 + 32'({nb_r, 2'b00}) + 32'(nb_r) + 32'(total_r);
  end

  // Adler-32 update for the current payload byte
  assign lo_s = 17'(alo_r) + 17'(byte_v);
  assign lo_n = (lo_s >= 17'(psde_pkg::ADLER_MOD)) ?
                16'(lo_s - 17'(psde_pkg::ADLER_MOD)) : lo_s[15:0];
  assign hi_s = 17'(ahi_r) + 17'(lo_n);
  assign hi_n = (hi_s >= 17'(psde_pkg::ADLER_MOD)) ?
                16'(hi_s - 17'(psde_pkg::ADLER_MOD)) : hi_s[15:0];

  always_comb begin
    byte_v  = '0;
    emit    = 1'b0;
    crc_en  = 1'b0;
    crc_rst = 1'b0;
    last    = 1'b0;
    fend    = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_HDR: begin
        emit = 1'b1;
        if (idx_r < 6'd8) byte_v = psde_pkg::signature(idx_r[2:0]);
        else if (idx_r < 6'd12) byte_v = psde_pkg::be_byte(32'd13, idx_r[1:0]);
        else if (idx_r < 6'd16) begin
          crc_en = 1'b1;
          crc_rst = (idx_r == 6'd12);
          case (idx_r[1:0])
            2'd0:    byte_v = "I";
            2'd1:    byte_v = "H";
            2'd2:    byte_v = "D";
            default: byte_v = "R";
          endcase
        end else if (idx_r < 6'd20) begin
          crc_en = 1'b1;
          byte_v = psde_pkg::be_byte(32'(eff_w), idx_r[1:0]);
        end else if (idx_r < 6'd24) begin
          crc_en = 1'b1;
          byte_v = psde_pkg::be_byte(32'(eff_h), idx_r[1:0]);
        end else if (idx_r < 6'd29) begin
          crc_en = 1'b1;
          byte_v = (idx_r == 6'd24) ? 8'd8 : (idx_r == 6'd25) ? 8'd6 : 8'd0;
        end else if (idx_r < 6'd33) begin
          byte_v = psde_pkg::be_byte(~crc_r, 2'(idx_r - 6'd29));
        end else if (idx_r < 6'd37) begin
          byte_v = psde_pkg::be_byte(idat_len_r, 2'(idx_r - 6'd33));
        end else begin
          crc_en = 1'b1;
          crc_rst = (idx_r == 6'd37);
          case (idx_r)
            6'd37:   byte_v = "I";
            6'd38:   byte_v = "D";
            6'd39:   byte_v = "A";
            6'd40:   byte_v = "T";
            6'd41:   byte_v = 8'h78;
            default: byte_v = 8'h01;
          endcase
        end
      end
      ST_BHDR: begin
        emit = 1'b1;
        crc_en = 1'b1;
        case (idx_r[2:0])
          3'd0:    byte_v = {7'd0, 27'(blk_n) == fleft_r};
          3'd1:    byte_v = blk_n[7:0];
          3'd2:    byte_v = blk_n[15:8];
          3'd3:    byte_v = ~blk_n[7:0];
          default: byte_v = ~blk_n[15:8];
        endcase
      end
      ST_PAY: begin
        emit = 1'b1;
        crc_en = 1'b1;
        byte_v = filt_r ? 8'd0 : cmd_r.data;
        last = !filt_r && !cmd_r.finish;
      end
      ST_TAIL: begin
        emit = 1'b1;
        if (idx_r < 6'd4) begin
          crc_en = 1'b1;
          byte_v = psde_pkg::be_byte({ahi_r, alo_r}, idx_r[1:0]);
        end else if (idx_r < 6'd8) begin
          byte_v = psde_pkg::be_byte(~crc_r, idx_r[1:0]);
        end else if (idx_r < 6'd12) begin
          byte_v = 8'd0;
        end else if (idx_r < 6'd16) begin
          crc_en = 1'b1;
          crc_rst = (idx_r == 6'd12);
          case (idx_r[1:0])
            2'd0:    byte_v = "I";
            2'd1:    byte_v = "E";
            2'd2:    byte_v = "N";
            default: byte_v = "D";
          endcase
        end else begin
          byte_v = psde_pkg::be_byte(~crc_r, idx_r[1:0]);
          last = (idx_r == TAIL_LAST);
          fend = (idx_r == TAIL_LAST);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    filt_nxt  = filt_r;
    crc_nxt   = crc_r;
    alo_nxt   = alo_r;
    ahi_nxt   = ahi_r;
    brem_nxt  = brem_r;
    fleft_nxt = fleft_r;
    if (state_r == ST_IDLE) begin
      // take the next command and pick where it starts
      if (q_valid) begin
        filt_nxt = q_cmd.row_start;
        idx_nxt  = '0;
        if (q_cmd.start) state_nxt = ST_HDR;
        else if (brem_r == '0) state_nxt = ST_BHDR;
        else state_nxt = ST_PAY;
      end
    end else if (adv && emit) begin
      if (crc_en) crc_nxt = psde_pkg::crc_byte(crc_rst ? psde_pkg::CRC_INIT : crc_r, byte_v);
      idx_nxt = idx_r + 1'b1;
      unique case (state_r)
        ST_HDR: begin
          if (idx_r == HDR_LAST) begin
            fleft_nxt = total_r;
            brem_nxt  = '0;
            alo_nxt   = 16'd1;
            ahi_nxt   = 16'd0;
            idx_nxt   = '0;
            state_nxt = ST_BHDR;
          end
        end
        ST_BHDR: begin
          if (idx_r == BHDR_LAST) begin
            brem_nxt  = blk_n;
            state_nxt = ST_PAY;
          end
        end
        ST_PAY: begin
          alo_nxt   = lo_n;
          ahi_nxt   = hi_n;
          brem_nxt  = brem_r - 1'b1;
          fleft_nxt = fleft_r - 1'b1;
          idx_nxt   = '0;
          if (filt_r) begin
            filt_nxt  = 1'b0;
            state_nxt = (brem_r == 16'd1) ? ST_BHDR : ST_PAY;
          end else begin
            state_nxt = cmd_r.finish ? ST_TAIL : ST_IDLE;
          end
        end
        ST_TAIL: begin
          if (idx_r == TAIL_LAST) state_nxt = ST_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid) cmd_r <= q_cmd;
    if (adv) begin
      ob_r <= byte_v;
      ol_r <= last;
      oe_r <= fend;
    end
    idx_r   <= idx_nxt;
    filt_r  <= filt_nxt;
    alo_r   <= alo_nxt;
    ahi_r   <= ahi_nxt;
    fleft_r <= fleft_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      crc_r   <= psde_pkg::CRC_INIT;
      brem_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (adv) ov_r <= emit;
      crc_r   <= crc_nxt;
      brem_r  <= brem_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_last_of_run = ol_r;
  assign out_file_end    = oe_r;

endmodule

### rtl/png_stored_deflate_encoder.sv
// Top level of the PNG encoder with stored deflate blocks.
// Depends on psde_pkg, psde_front, psde_fifo, psde_back and the assertion header.
//
// Feed an RGBA frame one byte per item, row-major, R G B A order; the block
// writes a complete 8-bit RGBA PNG file one byte per result item: signature,
// IHDR, one IDAT with a zlib stream of stored blocks (up to 65535 bytes each,
// filter byte 0 before every row, Adler-32 at the end), and IEND. The first
// byte of a frame also produces the 43 header bytes plus the first block
// header and filter byte; the last byte is followed by the 20-byte trailer,
// flagged with file_end on its last byte. last_of_run marks the final result
// of each input item. frame_width and frame_height (index 0 and 1) take 1 to
// 4096; 0 reads as 1 and larger values as 4096. Writing either register
// drops any file in progress, so the next byte starts a new file. Write them
// only while the encoder is idle. Throughput is set by the back-end byte
// sequencer, which emits one output byte per cycle while out_ready is high
// and has a dispatch state per item: a plain pixel byte is dispatched
// and sent, after the filter byte at a row start and after a block header
// where one falls; the first byte of a frame runs dispatch, 43 header
// bytes, block header, filter byte, the byte itself, and the last adds
// the trailer. A two-entry queue lets input run while the sequencer drains.
`timescale 1ns / 1ps
`include "png_stored_deflate_encoder_assert.svh"
module png_stored_deflate_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_last_of_run,
  output logic                           out_file_end,
  input  logic                           cfg_we,
  input  logic [psde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psde_pkg::DIM_W-1:0]     cfg_data
);

  logic [psde_pkg::DIM_W-1:0]   width_r, height_r;
  logic [psde_pkg::DIM_W-1:0]   eff_w, eff_h;
  logic                         fq_valid, fq_ready, bq_valid, bq_pop;
  psde_pkg::psde_cmd_t          fq_cmd, bq_cmd;
  logic [psde_pkg::Q_CNT_W-1:0] q_count;

  // hold the frame size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= psde_pkg::WIDTH_RESET;
      height_r <= psde_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psde_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_data;
        psde_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to the supported range; IHDR carries the clamped values
  assign eff_w = psde_pkg::eff_width(width_r);
  assign eff_h = psde_pkg::eff_height(height_r);

  psde_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .cfg_we       (cfg_we),
    .eff_w        (eff_w),
    .eff_h        (eff_h),
    .q_ready      (fq_ready),
    .q_valid      (fq_valid),
    .q_cmd        (fq_cmd)
  );

  psde_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (bq_valid),
    .rd_pop   (bq_pop),
    .rd_cmd   (bq_cmd),
    .count    (q_count)
  );

  psde_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .eff_w           (eff_w),
    .eff_h           (eff_h),
    .q_valid         (bq_valid),
    .q_pop           (bq_pop),
    .q_cmd           (bq_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_file_end    (out_file_end)
  );

  `PSDE_ASSERT(a_end_is_last, out_valid && out_file_end |-> out_last_of_run)
  `PSDE_ASSERT(a_queue_bound, q_count <= psde_pkg::Q_CNT_W'(psde_pkg::Q_DEPTH))
  `PSDE_ASSERT(a_full_stalls, q_count == psde_pkg::Q_CNT_W'(psde_pkg::Q_DEPTH) |-> !in_ready)
  `PSDE_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid)

endmodule

### bench/png_stored_deflate_encoder_tb.sv
// Testbench for the PNG stored-deflate encoder: drives RGBA frames and checks the PNG bytes.
// Depends on psde_pkg and the png_stored_deflate_encoder RTL.
`timescale 1ns / 1ps

// Holds the expected PNG bytes, computed by an independent model of the encoder.
class png_byte_scoreboard;
  typedef struct packed {
    logic [7:0] file_byte;
    logic       run_end;
    logic       file_last;
  } png_out_t;

  png_out_t    pending_bytes[$];
  logic [12:0] width_reg, height_reg;
  bit          in_file;
  int unsigned row_pos, rows_done, block_left, filtered_left;
  logic [31:0] crc;
  int unsigned adler_lo, adler_hi;
  int          mismatches;

  function void reset_state();
    width_reg = psde_pkg::WIDTH_RESET;
    height_reg = psde_pkg::HEIGHT_RESET;
    in_file = 0;
    crc = psde_pkg::CRC_INIT;
    adler_lo = 1;
    adler_hi = 0;
    pending_bytes.delete();
    mismatches = 0;
  endfunction

  function int unsigned clamp_dim(logic [12:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function void write_reg(logic [psde_pkg::CFG_IDX_W-1:0] idx, logic [12:0] val);
    if (idx == psde_pkg::REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    in_file = 0;
  endfunction

  function void emit(logic [7:0] b);
    png_out_t r;
    r.file_byte = b;
    r.run_end = 0;
    r.file_last = 0;
    pending_bytes.insert(pending_bytes.size(), r);
  endfunction

  function void emit_crc(logic [7:0] b);
    crc = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) crc = (crc >> 1) ^ (32'hEDB88320 & {32{crc[0]}});
    emit(b);
  endfunction

  function void emit_word(logic [31:0] v, bit with_crc);
    for (int s = 24; s >= 0; s -= 8)
      if (with_crc) emit_crc(v[s+:8]); else emit(v[s+:8]);
  endfunction

  function void emit_chunk_type(string t);
    crc = 32'hFFFFFFFF;
    for (int i = 0; i < 4; i++) emit_crc(t[i]);
  endfunction

  function void open_file();
    int unsigned w, h, total, nblk;
    byte unsigned sig[8] = '{137, 80, 78, 71, 13, 10, 26, 10};
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    total = (4 * w + 1) * h;
    nblk = (total + 65534) / 65535;
    foreach (sig[i]) emit(sig[i]);
    emit_word(13, 0);
    emit_chunk_type("IHDR");
    emit_word(w, 1);
    emit_word(h, 1);
    emit_crc(8); emit_crc(6); emit_crc(0); emit_crc(0); emit_crc(0);
    emit_word(~crc, 0);
    emit_word(2 + 5 * nblk + total + 4, 0);
    emit_chunk_type("IDAT");
    emit_crc(8'h78);
    emit_crc(8'h01);
    filtered_left = total;
    block_left = 0;
    row_pos = 0;
    rows_done = 0;
    adler_lo = 1;
    adler_hi = 0;
    in_file = 1;
  endfunction

  // Put one filtered byte into the stream, opening a stored block where needed.
  function void stream_byte(logic [7:0] b);
    int unsigned n;
    logic [15:0] inv;
    if (block_left == 0) begin
      n = (filtered_left < 65535) ? filtered_left : 65535;
      inv = ~n[15:0];
      emit_crc((n == filtered_left) ? 8'd1 : 8'd0);
      emit_crc(n[7:0]);
      emit_crc(n[15:8]);
      emit_crc(inv[7:0]);
      emit_crc(inv[15:8]);
      block_left = n;
    end
    emit_crc(b);
    block_left--;
    filtered_left--;
    adler_lo = (adler_lo + b) % 65521;
    adler_hi = (adler_hi + adler_lo) % 65521;
  endfunction

  // Note an accepted pixel byte and queue every PNG byte it causes.
  function void note_pixel_byte(logic [7:0] b);
    if (!in_file) open_file();
    if (row_pos == 0) stream_byte(8'd0);
    stream_byte(b);
    row_pos++;
    if (row_pos >= 4 * clamp_dim(width_reg)) begin
      row_pos = 0;
      rows_done++;
      if (rows_done >= clamp_dim(height_reg)) begin
        emit_word({adler_hi[15:0], adler_lo[15:0]}, 1);
        emit_word(~crc, 0);
        emit_word(0, 0);
        emit_chunk_type("IEND");
        emit_word(~crc, 0);
        pending_bytes[$].file_last = 1;
        in_file = 0;
      end
    end
    pending_bytes[$].run_end = 1;
  endfunction

  function void check_byte(logic [7:0] b, logic lr, logic fe);
    png_out_t e;
    if (pending_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected output byte %0d", b);
      return;
    end
    e = pending_bytes[0];
    pending_bytes.delete(0);
    if (e.file_byte !== b || e.run_end !== lr || e.file_last !== fe) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: byte exp %0d/%0b/%0b got %0d/%0b/%0b",
                 e.file_byte, e.run_end, e.file_last, b, lr, fe);
    end
  endfunction
endclass

module png_stored_deflate_encoder_tb;

  localparam int STALL_LIMIT = 20000;

  logic                           clk = 0;
  logic                           rst_n = 0;
  logic                           in_valid = 0;
  logic                           in_ready;
  logic [7:0]                     in_data_byte = 0;
  logic                           out_valid;
  logic                           out_ready = 0;
  logic [7:0]                     out_byte;
  logic                           out_last_of_run;
  logic                           out_file_end;
  logic                           cfg_we = 0;
  logic [psde_pkg::CFG_IDX_W-1:0] cfg_index = psde_pkg::REG_FRAME_WIDTH;
  logic [psde_pkg::DIM_W-1:0]     cfg_data = 0;

  png_byte_scoreboard png_sb = new();
  bit   quiet_phase = 0;
  int   idle_cycles = 0;

  png_stored_deflate_encoder dut (.*);

  always #10 clk = ~clk;

  // Sample both handshakes at the rising edge; watchdog counts idle cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) png_sb.note_pixel_byte(in_data_byte);
      if (out_valid && out_ready) png_sb.check_byte(out_byte, out_last_of_run, out_file_end);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: stall in random bursts, except in the quiet phase.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        stall = $urandom_range(1, 3);
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  // Offer one pixel byte and hold it until accepted; maybe gap first.
  // Valid stays high after the accepting edge; the caller drops it.
  task automatic send_pixel(logic [7:0] b);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain all expected bytes, let the sequencer settle, then write a register.
  task automatic write_dim(logic [psde_pkg::CFG_IDX_W-1:0] idx,
                           logic [psde_pkg::DIM_W-1:0] val);
    in_valid <= 0;
    while (png_sb.pending_bytes.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    png_sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Send a whole frame (or part of one) of random bytes.
  task automatic send_frame(int n_bytes);
    for (int i = 0; i < n_bytes; i++) send_pixel(8'($urandom_range(0, 255)));
  endtask

  initial begin
    png_sb.reset_state();
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: smallest frame, extremes of the byte, zero dims clamp to 1.
    write_dim(psde_pkg::REG_FRAME_WIDTH, 1);
    write_dim(psde_pkg::REG_FRAME_HEIGHT, 1);
    send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'hAA); send_pixel(8'h55);
    write_dim(psde_pkg::REG_FRAME_WIDTH, 0);
    write_dim(psde_pkg::REG_FRAME_HEIGHT, 0);
    send_pixel(8'h01); send_pixel(8'h80); send_pixel(8'h7F); send_pixel(8'hFE);
    // Oversized width clamps to 4096; abandon partway through the first row.
    write_dim(psde_pkg::REG_FRAME_WIDTH, 13'h1FFF);
    write_dim(psde_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
    send_frame(6);
    // 2x2 frame, abandoned mid-frame by a height write.
    write_dim(psde_pkg::REG_FRAME_WIDTH, 2);
    write_dim(psde_pkg::REG_FRAME_HEIGHT, 2);
    send_frame(10);
    write_dim(psde_pkg::REG_FRAME_HEIGHT, 2);

    // Random: mostly complete small frames, some truncated ones.
    for (int f = 0; f < 17; f++) begin
      int w, h, n;
      w = $urandom_range(1, 4);
      h = $urandom_range(1, 3);
      write_dim(psde_pkg::REG_FRAME_WIDTH, psde_pkg::DIM_W'(w));
      write_dim(psde_pkg::REG_FRAME_HEIGHT, psde_pkg::DIM_W'(h));
      n = 4 * w * h;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (f == 14) quiet_phase = 1;
      send_frame(n);
    end
    // Keep going with one setting: the next byte continues or reopens a file.
    send_frame(8);
    in_valid <= 0;

    while (png_sb.pending_bytes.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (png_sb.mismatches == 0 && png_sb.pending_bytes.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
